// ===== rtl/jbr_pkg.sv =====
// jbr_pkg: shared constants, codes and payload types for the JPEG bit reader.
// No dependencies; every other file in rtl/ uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package jbr_pkg;

  localparam int STORE_BITS     = 32;
  localparam int MAX_FIELD_BITS = 16;

  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int WIDTH_W = 5;
  localparam int FIELD_W = 16;
  localparam int STAT_W  = 2;
  localparam int HELD_W  = $clog2(STORE_BITS + 1);

  localparam logic [BYTE_W-1:0] BYTE_FF = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_00 = 8'h00;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_REQUEST = 2'd1,
    OP_ALIGN   = 2'd2,
    OP_EOS     = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_WIDTH = 2'd1,
    ST_EOS       = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [BYTE_W-1:0]  data_byte;
    logic [WIDTH_W-1:0] bit_width;
  } item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] field_value;
    logic [STAT_W-1:0]  status;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/jbr_ifs.sv =====
// jbr_ifs: valid/ready channel interfaces for commands and results.
// Depends on jbr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface jbr_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [jbr_pkg::OP_W-1:0]    op;
  logic [jbr_pkg::BYTE_W-1:0]  data_byte;
  logic [jbr_pkg::WIDTH_W-1:0] bit_width;

  modport source (output valid, op, data_byte, bit_width, input ready);
  modport sink   (input valid, op, data_byte, bit_width, output ready);
endinterface

interface jbr_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [jbr_pkg::FIELD_W-1:0] field_value;
  logic [jbr_pkg::STAT_W-1:0]  status;

  modport source (output valid, field_value, status, input ready);
  modport sink   (input valid, field_value, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/jbr_in_stage.sv =====
// jbr_in_stage: input register for command words.
// Depends on jbr_pkg and jbr_cmd_if.
`timescale 1ns / 1ps
`default_nettype none

module jbr_in_stage (
  input  logic            clk,
  input  logic            rst,
  jbr_cmd_if.sink         cmd,
  input  logic            advance,
  output logic            item_valid,
  output jbr_pkg::item_t  item
);

  logic accept;

  assign cmd.ready = !item_valid || advance;
  assign accept    = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.op        <= cmd.op;
      item.data_byte <= cmd.data_byte;
      item.bit_width <= cmd.bit_width;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jbr_core.sv =====
// jbr_core: bit store, unstuffing and field extraction; one word per cycle while go is high.
// Depends on jbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jbr_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  jbr_pkg::item_t   item,
  output logic             res_valid,
  output jbr_pkg::result_t res
);

  localparam int SB = jbr_pkg::STORE_BITS;
  localparam int HW = jbr_pkg::HELD_W;
  localparam int WW = jbr_pkg::WIDTH_W;
  localparam int FW = jbr_pkg::FIELD_W;

  logic [SB-1:0] bit_store, bit_store_next;
  logic [HW-1:0] bits_held, bits_held_next;
  logic          after_ff, after_ff_next;
  logic [WW-1:0] waiting_width, waiting_width_next;
  logic          request_waiting, request_waiting_next;

  logic [SB-1:0] src_store;
  logic [HW-1:0] src_held;
  logic          take_en;
  logic [WW-1:0] take_w;
  logic [HW-1:0] take_w_ext;
  logic [HW-1:0] taken_held;
  logic [SB-1:0] shifted;
  logic [FW-1:0] field_mask;
  logic [HW-1:0] aligned_held;
  jbr_pkg::op_t  op;

  assign op           = jbr_pkg::op_t'(item.op);
  assign take_w_ext   = HW'(take_w);
  assign taken_held   = src_held - take_w_ext;
  assign shifted      = src_store >> taken_held;
  assign field_mask   = ~({FW{1'b1}} << take_w);
  assign aligned_held = {bits_held[HW-1:3], 3'b000};

  always_comb begin
    bit_store_next       = bit_store;
    bits_held_next       = bits_held;
    after_ff_next        = after_ff;
    waiting_width_next   = waiting_width;
    request_waiting_next = request_waiting;
    src_store            = bit_store;
    src_held             = bits_held;
    take_en              = 1'b0;
    take_w               = item.bit_width;
    res_valid            = 1'b0;
    res.field_value      = '0;
    res.status           = jbr_pkg::ST_OK;

    unique case (op)
      jbr_pkg::OP_PUSH: begin
        if (after_ff && item.data_byte == jbr_pkg::BYTE_00) begin
          // stuffed zero after 0xFF: drop it
          after_ff_next = 1'b0;
        end else if (bits_held + HW'(8) > HW'(SB)) begin
          after_ff_next = 1'b0;
          res_valid     = 1'b1;
          res.status    = jbr_pkg::ST_OVERFLOW;
        end else begin
          src_store      = (bit_store << 8) | SB'(item.data_byte);
          src_held       = bits_held + HW'(8);
          bit_store_next = src_store;
          bits_held_next = src_held;
          after_ff_next  = (item.data_byte == jbr_pkg::BYTE_FF);
          if (request_waiting && src_held >= HW'(waiting_width)) begin
            take_en              = 1'b1;
            take_w               = waiting_width;
            request_waiting_next = 1'b0;
            res_valid            = 1'b1;
          end
        end
      end
      jbr_pkg::OP_REQUEST: begin
        if (item.bit_width > WW'(jbr_pkg::MAX_FIELD_BITS)) begin
          res_valid  = 1'b1;
          res.status = jbr_pkg::ST_BAD_WIDTH;
        end else if (bits_held >= HW'(item.bit_width)) begin
          take_en              = 1'b1;
          request_waiting_next = 1'b0;
          res_valid            = 1'b1;
        end else begin
          // hold the request until pushes bring enough bits
          waiting_width_next   = item.bit_width;
          request_waiting_next = 1'b1;
        end
      end
      jbr_pkg::OP_ALIGN: begin
        // drop the unread rest of the partly consumed byte
        bits_held_next = aligned_held;
        bit_store_next = bit_store & ~({SB{1'b1}} << aligned_held);
      end
      jbr_pkg::OP_EOS: begin
        if (request_waiting) begin
          request_waiting_next = 1'b0;
          res_valid            = 1'b1;
          res.status           = jbr_pkg::ST_EOS;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase

    if (take_en) begin
      res.field_value = shifted[FW-1:0] & field_mask;
      bits_held_next  = taken_held;
      bit_store_next  = src_store & ~({SB{1'b1}} << taken_held);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_store       <= '0;
      bits_held       <= '0;
      after_ff        <= 1'b0;
      waiting_width   <= '0;
      request_waiting <= 1'b0;
    end else if (go) begin
      bit_store       <= bit_store_next;
      bits_held       <= bits_held_next;
      after_ff        <= after_ff_next;
      waiting_width   <= waiting_width_next;
      request_waiting <= request_waiting_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jbr_out_stage.sv =====
// jbr_out_stage: result register that holds a word until the sink takes it.
// Depends on jbr_pkg and jbr_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module jbr_out_stage (
  input  logic             clk,
  input  logic             rst,
  jbr_rsp_if.source        rsp,
  input  logic             load,
  input  jbr_pkg::result_t res,
  output logic             can_load
);

  logic                        valid;
  logic [jbr_pkg::FIELD_W-1:0] field_value;
  logic [jbr_pkg::STAT_W-1:0]  status;

  assign can_load        = !valid || rsp.ready;
  assign rsp.valid       = valid;
  assign rsp.field_value = field_value;
  assign rsp.status      = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      field_value <= res.field_value;
      status      <= res.status;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jpeg_bit_reader_unstuff.sv =====
// jpeg_bit_reader_unstuff: top level of the JPEG entropy bit reader.
// Depends on jbr_pkg, jbr_ifs, jbr_in_stage, jbr_core, jbr_out_stage.
//
//   channel | dir | payload                        | handshake
//   --------+-----+--------------------------------+-------------
//   cmd     | in  | op, data_byte, bit_width       | valid/ready
//   rsp     | out | field_value, status            | valid/ready
//
// A word is registered on accept, processed by the core when it advances and its
// result, if any, is registered for rsp.
// One word per cycle while rsp is taken.
// rsp backpressure stalls the core and then the input register.
// rst (synchronous) empties the bit store and both registers.
`timescale 1ns / 1ps
`default_nettype none

module jpeg_bit_reader_unstuff (
  input  logic      clk,
  input  logic      rst,
  jbr_cmd_if.sink   cmd,
  jbr_rsp_if.source rsp
);

  logic             item_valid;
  jbr_pkg::item_t   item;
  logic             can_load;
  logic             advance;
  logic             res_valid;
  jbr_pkg::result_t res;

  assign advance = item_valid && can_load;

  jbr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  jbr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  jbr_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .rsp      (rsp),
    .load     (advance && res_valid),
    .res      (res),
    .can_load (can_load)
  );

endmodule

`default_nettype wire

// ===== rtl/jbr_checker.sv =====
// jbr_checker: port-level assertions for jpeg_bit_reader_unstuff, and its bind.
// Depends on jbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jbr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [jbr_pkg::FIELD_W-1:0] rsp_field_value,
  input logic [jbr_pkg::STAT_W-1:0]  rsp_status
);

  // reset empties both registers
  a_reset_clear: assert property (@(posedge clk) rst |=> !rsp_valid && cmd_ready)
    else $error("reset did not clear rsp valid / cmd ready");

  // a free result register never blocks commands
  a_free_ready: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> cmd_ready)
    else $error("cmd stalled with empty result register");

  // failed results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != jbr_pkg::ST_OK |-> rsp_field_value == '0)
    else $error("error status with nonzero field value");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_field_value)
      && $stable(rsp_status))
    else $error("stalled result word changed");

endmodule

bind jpeg_bit_reader_unstuff jbr_checker u_chk (
  .clk             (clk),
  .rst             (rst),
  .cmd_ready       (cmd.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_field_value (rsp.field_value),
  .rsp_status      (rsp.status)
);

`default_nettype wire

// ===== sim/tb_jpeg_bit_reader_unstuff.sv =====
// tb_jpeg_bit_reader_unstuff: self-checking bench for the JPEG bit reader, with a
// bit-exact predictor of fields, stuffing, bad-width, overflow and end-of-stream status.
// Depends on rtl/jbr_pkg.sv, rtl/jbr_ifs.sv and rtl/jpeg_bit_reader_unstuff.sv.
`timescale 1ns / 1ps

class bit_field_scoreboard;
  logic [63:0] bit_store;
  int unsigned bits_held;
  bit          after_ff;
  int unsigned waiting_width;
  bit          request_waiting;
  jbr_pkg::result_t pending_fields[$];
  int unsigned errors;

  function new();
    bit_store       = '0;
    bits_held       = 0;
    after_ff        = 1'b0;
    waiting_width   = 0;
    request_waiting = 1'b0;
    errors          = 0;
  endfunction

  function void add_field(logic [15:0] value, jbr_pkg::status_t st);
    jbr_pkg::result_t r;
    r.field_value = value;
    r.status      = st;
    pending_fields.push_back(r);
  endfunction

  // Take the oldest w held bits, first bit most significant.
  function logic [15:0] take_bits(int unsigned w);
    logic [63:0] v;
    if (w == 0) return '0;
    v = (bit_store >> (bits_held - w)) & ((64'd1 << w) - 64'd1);
    bits_held -= w;
    bit_store &= (64'd1 << bits_held) - 64'd1;
    return v[15:0];
  endfunction

  function void note_command(jbr_pkg::op_t op, logic [7:0] b, logic [4:0] w);
    case (op)
      jbr_pkg::OP_PUSH: begin
        if (after_ff && b == jbr_pkg::BYTE_00) begin
          after_ff = 1'b0;
        end else if (bits_held + 8 > jbr_pkg::STORE_BITS) begin
          after_ff = 1'b0;
          add_field('0, jbr_pkg::ST_OVERFLOW);
        end else begin
          bit_store = ((bit_store << 8) | {56'd0, b}) &
                      ((64'd1 << jbr_pkg::STORE_BITS) - 64'd1);
          bits_held += 8;
          after_ff = (b == jbr_pkg::BYTE_FF);
          if (request_waiting && bits_held >= waiting_width) begin
            request_waiting = 1'b0;
            add_field(take_bits(waiting_width), jbr_pkg::ST_OK);
          end
        end
      end
      jbr_pkg::OP_REQUEST: begin
        if (w > jbr_pkg::MAX_FIELD_BITS) begin
          add_field('0, jbr_pkg::ST_BAD_WIDTH);
        end else if (bits_held >= w) begin
          request_waiting = 1'b0;
          add_field(take_bits(w), jbr_pkg::ST_OK);
        end else begin
          waiting_width   = w;
          request_waiting = 1'b1;
        end
      end
      jbr_pkg::OP_ALIGN: begin
        bits_held -= bits_held % 8;
        bit_store &= (64'd1 << bits_held) - 64'd1;
      end
      default: begin
        if (request_waiting) begin
          request_waiting = 1'b0;
          add_field('0, jbr_pkg::ST_EOS);
        end
      end
    endcase
  endfunction

  function void check_field(logic [15:0] fv, logic [1:0] st);
    jbr_pkg::result_t exp;
    if (pending_fields.size() == 0) begin
      $error("unexpected word: field_value %0h status %0d", fv, st);
      errors++;
      return;
    end
    exp = pending_fields.pop_front();
    if (fv !== exp.field_value) begin
      $error("field_value: expected %0h, actual %0h", exp.field_value, fv);
      errors++;
    end
    if (st !== exp.status) begin
      $error("status: expected %0d, actual %0d", exp.status, st);
      errors++;
    end
  endfunction
endclass

module tb_jpeg_bit_reader_unstuff;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES     = 10;
  localparam int PHASE_LEN  = 105;

  logic clk;
  logic rst;
  bit   calm;

  jbr_cmd_if cmd ();
  jbr_rsp_if rsp ();

  bit_field_scoreboard sb;

  jpeg_bit_reader_unstuff uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned draw_gap();
    if (calm) return 0;
    return $urandom_range(0, 14);
  endfunction

  // Present one word and hold it until accepted.
  task automatic send_word(jbr_pkg::op_t op, logic [7:0] b, logic [4:0] w);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid     <= 1'b1;
    cmd.op        <= op;
    cmd.data_byte <= b;
    cmd.bit_width <= w;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    sb.note_command(op, b, w);
  endtask

  task automatic push_byte(logic [7:0] b);
    send_word(jbr_pkg::OP_PUSH, b, 5'($urandom));
  endtask

  task automatic request_bits(logic [4:0] w);
    send_word(jbr_pkg::OP_REQUEST, 8'($urandom), w);
  endtask

  // Hold the sender until every expected field has come back.
  task automatic drain();
    cmd.valid <= 1'b0;
    while (sb.pending_fields.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_word(int unsigned push_pct);
    int unsigned r;
    logic [7:0]  b;
    logic [4:0]  w;
    r = $urandom_range(0, 99);
    b = 8'($urandom);
    w = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 16));
    if (r < push_pct) begin
      case ($urandom_range(0, 6))
        0: b = jbr_pkg::BYTE_FF;
        1: b = jbr_pkg::BYTE_00;
        default: ;
      endcase
      send_word(jbr_pkg::OP_PUSH, b, w);
    end else begin
      r = $urandom_range(0, 9);
      if (r < 8)       send_word(jbr_pkg::OP_REQUEST, b, w);
      else if (r == 8) send_word(jbr_pkg::OP_ALIGN, b, w);
      else             send_word(jbr_pkg::OP_EOS, b, w);
    end
  endtask

  // Result side: stall, then take one word and check it.
  initial begin
    int unsigned stall;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      sb.check_field(rsp.field_value, rsp.status);
    end
  end

  // Watchdog: end the run after too many cycles without any accepted word.
  initial begin
    int unsigned idle;
    idle = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) idle = 0;
      else idle++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned push_pct;
    sb = new();
    calm          = 1'b0;
    rst           <= 1'b1;
    cmd.valid     <= 1'b0;
    cmd.op        <= jbr_pkg::OP_PUSH;
    cmd.data_byte <= '0;
    cmd.bit_width <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty end of stream, zero and bad widths, waiting requests.
    send_word(jbr_pkg::OP_EOS, 8'($urandom), 5'($urandom));
    request_bits(5'd0);
    request_bits(5'd17);
    request_bits(5'd31);
    request_bits(5'd5);
    request_bits(5'd20);
    push_byte(8'hA5);
    // Stuffing: FF 00 drops the zero, also when the store has no room for another byte.
    push_byte(jbr_pkg::BYTE_FF);
    push_byte(jbr_pkg::BYTE_00);
    push_byte(jbr_pkg::BYTE_FF);
    push_byte(jbr_pkg::BYTE_00);
    push_byte(jbr_pkg::BYTE_FF);
    push_byte(jbr_pkg::BYTE_00);
    push_byte(8'h7E);
    request_bits(5'd16);
    send_word(jbr_pkg::OP_ALIGN, 8'($urandom), 5'($urandom));
    request_bits(5'd12);
    request_bits(5'd9);
    push_byte(jbr_pkg::BYTE_00);
    request_bits(5'd16);
    send_word(jbr_pkg::OP_EOS, 8'($urandom), 5'($urandom));
    // FF followed by a nonzero byte keeps both.
    push_byte(jbr_pkg::BYTE_FF);
    push_byte(8'h3C);
    request_bits(5'd16);
    send_word(jbr_pkg::OP_ALIGN, 8'($urandom), 5'($urandom));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      push_pct = $urandom_range(25, 90);
      calm = (p % 3 == 1);
      for (int i = 0; i < PHASE_LEN; i++) random_word(push_pct);
      if (p == PHASES / 2) drain();
    end
    calm = 1'b0;

    cmd.valid <= 1'b0;
    while (sb.pending_fields.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== jpeg_bit_reader_unstuff.f =====
rtl/jbr_pkg.sv
rtl/jbr_ifs.sv
rtl/jbr_in_stage.sv
rtl/jbr_core.sv
rtl/jbr_out_stage.sv
rtl/jpeg_bit_reader_unstuff.sv
rtl/jbr_checker.sv
sim/tb_jpeg_bit_reader_unstuff.sv
